// ----- design/lsot_pkg.sv -----
// ----------------------------------------------------------------------------
// Leap-second offset table package
// Shared widths, operation codes and status codes for the offset table.
// ----------------------------------------------------------------------------
package lsot_pkg;

   localparam int TABLE_DEPTH_DEF = 64;

   localparam int OP_W     = 2;
   localparam int EPOCH_W  = 48;
   localparam int OFFSET_W = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_COVER = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_DUP   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

endpackage

// ----- design/lsot_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lsot_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/leap_second_offset_table_core.sv -----
// ----------------------------------------------------------------------------
// Leap-second offset table core
// Sorted table of (epoch, TAI-UTC offset) entries with clear, insert, lookup.
// ----------------------------------------------------------------------------
// Items are taken one at a time: a new request is accepted only in S_IDLE, and a
// held result stalls in S_RESP. Clear, an unused op and an empty lookup go straight
// to S_RESP. Lookup and insert scan the entries in order, each read in S_SCAN_RD and
// checked in S_SCAN_CMP through a shared 48-bit compare; a placed insert then moves
// the higher entries up one slot (S_SHIFT_RD, S_SHIFT_WR) and writes its own entry
// in S_PUT. Reset empties the table (count to zero); the RAM is not cleared.
// ----------------------------------------------------------------------------
module leap_second_offset_table_core #(
   parameter int TABLE_DEPTH = lsot_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lsot_pkg::OP_W-1:0]           req_op,
   input  logic [lsot_pkg::EPOCH_W-1:0]        req_epoch,
   input  logic signed [lsot_pkg::OFFSET_W-1:0] req_offset,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lsot_pkg::OFFSET_W-1:0] rsp_offset_out,
   output logic [lsot_pkg::STATUS_W-1:0]       rsp_status,
   output logic [lsot_pkg::COUNT_W-1:0]        rsp_entry_count
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int IDX_W = $clog2(TABLE_DEPTH + 1);
   localparam int EW    = lsot_pkg::EPOCH_W;
   localparam int OW    = lsot_pkg::OFFSET_W;
   localparam int ENT_W = EW + OW;
   localparam int CW    = lsot_pkg::COUNT_W;
   localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(TABLE_DEPTH);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_SCAN_RD  = 7'b0000010,
      S_SCAN_CMP = 7'b0000100,
      S_SHIFT_RD = 7'b0001000,
      S_SHIFT_WR = 7'b0010000,
      S_PUT      = 7'b0100000,
      S_RESP     = 7'b1000000
   } state_type;

   state_type                        state_ff, state_in;
   logic [IDX_W-1:0]                 count_ff, count_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic [IDX_W-1:0]                 pos_ff, pos_in;
   logic [lsot_pkg::OP_W-1:0]        op_ff, op_in;
   logic [EW-1:0]                    key_ff, key_in;
   logic [OW-1:0]                    off_ff, off_in;
   logic [OW-1:0]                    hit_off_ff, hit_off_in;
   logic                             last_eq_ff, last_eq_in;
   logic [OW-1:0]                    res_off_ff, res_off_in;
   logic [lsot_pkg::STATUS_W-1:0]    res_st_ff, res_st_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]                    rsp_off_ff, rsp_off_in;
   logic [lsot_pkg::STATUS_W-1:0]    rsp_st_ff, rsp_st_in;
   logic [CW-1:0]                    rsp_cnt_ff, rsp_cnt_in;

   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [ENT_W-1:0] ram_wdata;
   logic [AW-1:0]    ram_raddr;
   logic [ENT_W-1:0] ram_rdata;
   logic [EW-1:0]    rd_epoch;
   logic [OW-1:0]    rd_off;
   logic             cmp_lt;
   logic             cmp_eq;
   logic             place_start;
   logic [IDX_W-1:0] idx_dec;
   logic [IDX_W+CW-1:0] cnt_ext;

   lsot_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_epoch = ram_rdata[ENT_W-1:OW];
   assign rd_off   = ram_rdata[OW-1:0];

   // shared compare unit: item key against the entry just read
   assign cmp_lt  = key_ff < rd_epoch;
   assign cmp_eq  = key_ff == rd_epoch;
   assign idx_dec = idx_ff - IDX_W'(1);
   assign cnt_ext = {{CW{1'b0}}, count_ff};

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      off_in       = off_ff;
      hit_off_in   = hit_off_ff;
      last_eq_in   = last_eq_ff;
      res_off_in   = res_off_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_off_in   = rsp_off_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[AW-1:0];
      ram_wdata    = ram_rdata;
      ram_raddr    = idx_ff[AW-1:0];
      place_start  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_op;
               key_in     = req_epoch;
               off_in     = req_offset;
               idx_in     = '0;
               last_eq_in = 1'b0;
               res_off_in = '0;
               res_st_in  = lsot_pkg::STAT_OK;
               case (req_op)
                  lsot_pkg::OP_CLEAR: begin
                     count_in = '0;
                     state_in = S_RESP;
                  end
                  lsot_pkg::OP_INSERT: begin
                     state_in = S_SCAN_RD;
                  end
                  lsot_pkg::OP_LOOKUP: begin
                     if (count_ff == '0) begin
                        res_st_in = lsot_pkg::STAT_COVER;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_SCAN_RD;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               if (op_ff == lsot_pkg::OP_INSERT) begin
                  place_start = 1'b1;
               end else begin
                  // every entry is at or below the query: covered only on the last
                  if (last_eq_ff) begin
                     res_off_in = hit_off_ff;
                  end else begin
                     res_st_in = lsot_pkg::STAT_COVER;
                  end
                  state_in = S_RESP;
               end
            end else begin
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (op_ff == lsot_pkg::OP_INSERT) begin
               if (cmp_eq) begin
                  res_st_in = lsot_pkg::STAT_DUP;
                  state_in  = S_RESP;
               end else if (cmp_lt) begin
                  place_start = 1'b1;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_SCAN_RD;
               end
            end else begin
               if (cmp_lt) begin
                  if (idx_ff == '0) begin
                     res_st_in = lsot_pkg::STAT_COVER;
                  end else begin
                     res_off_in = hit_off_ff;
                  end
                  state_in = S_RESP;
               end else begin
                  hit_off_in = rd_off;
                  last_eq_in = cmp_eq;
                  idx_in     = idx_ff + IDX_W'(1);
                  state_in   = S_SCAN_RD;
               end
            end
         end
         S_SHIFT_RD: begin
            if (idx_ff == pos_ff) begin
               state_in = S_PUT;
            end else begin
               ram_raddr = idx_dec[AW-1:0];
               state_in  = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            // move entry idx-1 up one slot
            ram_we    = 1'b1;
            ram_waddr = idx_ff[AW-1:0];
            ram_wdata = ram_rdata;
            idx_in    = idx_dec;
            state_in  = S_SHIFT_RD;
         end
         S_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff[AW-1:0];
            ram_wdata = {key_ff, off_ff};
            count_in  = count_ff + IDX_W'(1);
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_off_in   = res_off_ff;
               rsp_st_in    = res_st_ff;
               rsp_cnt_in   = cnt_ext[CW-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // insert slot found: reject when full, else open the slot from the top
      if (place_start) begin
         if (count_ff == DEPTH_IDX) begin
            res_st_in = lsot_pkg::STAT_FULL;
            state_in  = S_RESP;
         end else begin
            pos_in   = idx_ff;
            idx_in   = count_ff;
            state_in = S_SHIFT_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      op_ff      <= op_in;
      key_ff     <= key_in;
      off_ff     <= off_in;
      hit_off_ff <= hit_off_in;
      last_eq_ff <= last_eq_in;
      res_off_ff <= res_off_in;
      res_st_ff  <= res_st_in;
      rsp_off_ff <= rsp_off_in;
      rsp_st_ff  <= rsp_st_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_offset_out  = rsp_off_ff;
   assign rsp_status      = rsp_st_ff;
   assign rsp_entry_count = rsp_cnt_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_IDX)
      else $error("entry count above table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (count_ff == '0) || (count_ff == $past(count_ff) + IDX_W'(1)))
      else $error("entry count moved other than clear or single insert");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while previous item still in work");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT_RD) |-> (idx_ff >= pos_ff) && (idx_ff < DEPTH_IDX))
      else $error("shift pointer outside the open slot range");

endmodule
